>>> design/dfr_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the length-prefixed deframer
package dfr_pkg;

  localparam int LEN_BYTES   = 8;
  localparam int LEN_CNT_W   = $clog2(LEN_BYTES + 1);
  localparam int LEN_POS_W   = 3;
  localparam int COUNT_W     = 64;
  localparam int BYTE_W      = 8;
  localparam int KIND_W      = 2;
  localparam int CFG_INDEX_W = 2;

  localparam logic [KIND_W-1:0] KIND_REPLY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GRANT = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_START = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACK   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NACK  = 2'd2;

  localparam logic [BYTE_W-1:0] START_RESET = 8'd1;
  localparam logic [BYTE_W-1:0] ACK_RESET   = 8'd2;
  localparam logic [BYTE_W-1:0] NACK_RESET  = 8'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] ack_code;
    logic [BYTE_W-1:0] nack_code;
  } codes_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] value;
    logic              last;
  } result_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_LEN  = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

endpackage

>>> design/dfr_cfg_regs.sv
`timescale 1ns / 1ps
// configuration registers for the start, ack and nack codes
module dfr_cfg_regs import dfr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]      cfg_data,
  output codes_t                 codes
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      codes.start_code <= START_RESET;
      codes.ack_code   <= ACK_RESET;
      codes.nack_code  <= NACK_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START: codes.start_code <= cfg_data;
        REG_ACK:   codes.ack_code   <= cfg_data;
        REG_NACK:  codes.nack_code  <= cfg_data;
        default:   ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

>>> design/dfr_in_reg.sv
`timescale 1ns / 1ps
// input register stage holding one received byte
module dfr_in_reg import dfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              item_valid,
  output logic [BYTE_W-1:0] item_byte,
  input  logic              item_take
);

  assign in_ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_byte <= rx_byte;
    end
  end

endmodule

>>> design/dfr_engine.sv
`timescale 1ns / 1ps
// frame state, length assembly, payload count and result register
module dfr_engine import dfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  codes_t            codes,
  input  logic              item_valid,
  input  logic [BYTE_W-1:0] item_byte,
  output logic              item_take,
  output logic              out_valid,
  input  logic              out_ready,
  output result_t           result
);

  phase_t                phase, phase_next;
  logic [LEN_CNT_W-1:0]  len_left, len_left_next;
  logic [COUNT_W-1:0]    remaining, remaining_next;
  logic [LEN_POS_W-1:0]  len_pos;
  logic                  load;
  result_t               result_next;

  assign item_take = item_valid && (!out_valid || out_ready);
  assign len_pos   = LEN_POS_W'(LEN_CNT_W'(LEN_BYTES) - len_left);

  always_comb begin
    phase_next     = phase;
    len_left_next  = len_left;
    remaining_next = remaining;
    load           = 1'b0;
    result_next    = '0;
    if (item_take) begin
      unique case (phase)
        PH_LEN: begin
          remaining_next = remaining |
                           ({{(COUNT_W-BYTE_W){1'b0}}, item_byte} << {len_pos, 3'b000});
          len_left_next  = len_left - 1'b1;
          if (len_left_next == '0) begin
            phase_next = (remaining_next == '0) ? PH_IDLE : PH_DATA;
          end
        end
        PH_DATA: begin
          remaining_next    = remaining - 1'b1;
          load              = 1'b1;
          result_next.kind  = KIND_DATA;
          result_next.value = item_byte;
          result_next.last  = (remaining_next == '0);
          if (remaining_next == '0) begin
            phase_next = PH_IDLE;
          end
        end
        default: begin
          load       = 1'b1;
          phase_next = PH_IDLE;
          priority if (item_byte == codes.start_code) begin
            phase_next        = PH_LEN;
            len_left_next     = LEN_CNT_W'(LEN_BYTES);
            remaining_next    = '0;
            result_next.kind  = KIND_REPLY;
            result_next.value = codes.ack_code;
          end else if (item_byte == codes.ack_code) begin
            result_next.kind  = KIND_GRANT;
          end else begin
            result_next.kind  = KIND_REPLY;
            result_next.value = codes.nack_code;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      len_left  <= '0;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      len_left  <= len_left_next;
      remaining <= remaining_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_last_only_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.last |-> result.kind == KIND_DATA)
    else $error("last flag on a non-payload result");
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.kind == KIND_GRANT |-> result.value == '0)
    else $error("grant result with nonzero value");
  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> remaining != '0)
    else $error("payload phase with zero count");
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_LEN |-> len_left != '0 && len_left <= LEN_CNT_W'(LEN_BYTES))
    else $error("length counter out of range");
  a_no_result_on_len: assert property (@(posedge clk) disable iff (rst)
    item_take && phase == PH_LEN |=> $stable(result))
    else $error("length byte changed the result register");
`endif

endmodule

>>> design/handshake_length_prefixed_deframer_core.sv
`timescale 1ns / 1ps
// top level of the length-prefixed frame receiver
//
// rx_byte items come in on in_valid/in_ready, one received byte per item.
// while idle, a start code opens a frame and yields a reply item carrying
// the ack code; the ack code yields a transmit-grant item (value zero);
// anything else yields a reply item carrying the nack code. after a start,
// eight length bytes (least significant first) form a 64-bit payload count
// and produce no item; each payload byte then comes out as a data item,
// the final one with last set. a zero count returns to idle at once.
// results leave on out_valid/out_ready as kind, value and last.
// out_valid rises once the byte has passed the input register and then
// the result register. throughput: one byte per cycle, sustained while
// out_ready stays high. when the receiver stalls, the result register
// holds and the input register fills; in_ready drops only when both are
// full. cfg writes (index 0 start, 1 ack, 2 nack) are registered; other
// indices are dropped. reset restores codes 1/2/3 and returns to idle.
module handshake_length_prefixed_deframer_core import dfr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]      cfg_data,
  // received byte channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [BYTE_W-1:0]      rx_byte,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [KIND_W-1:0]      kind,
  output logic [BYTE_W-1:0]      value,
  output logic                   last
);

  codes_t            codes;
  logic              item_valid;
  logic [BYTE_W-1:0] item_byte;
  logic              item_take;
  result_t           result;

  // programmable handshake codes
  dfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .codes     (codes)
  );

  // input register, frees up whenever the engine takes its byte
  dfr_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .item_valid (item_valid),
    .item_byte  (item_byte),
    .item_take  (item_take)
  );

  // frame tracking and result register
  dfr_engine u_eng (
    .clk        (clk),
    .rst        (rst),
    .codes      (codes),
    .item_valid (item_valid),
    .item_byte  (item_byte),
    .item_take  (item_take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  assign kind  = result.kind;
  assign value = result.value;
  assign last  = result.last;

endmodule
